>>> design/uelt_pkg.sv
// shared types, constants and codes for the undirected edge list table
package uelt_pkg;

    // default sizes
    localparam int MAX_EDGES_DEF   = 64;
    localparam int VERTEX_BITS_DEF = 8;

    // fixed field widths
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_VERTICES = 1'b0;

    // request operations
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_DEGREE = 2'd3
    } func_t;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_VERTEX = 2'd1,
        STATUS_FULL       = 2'd2
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_APPEND,
        ST_FETCH_LAST,
        ST_MOVE,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_issue;
        logic decide;
        logic append;
        logic fetch_last;
        logic move;
        logic result_load;
    } uelt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic  invalid;
        logic  count_zero;
        logic  scan_last;
        logic  hit;
        logic  full;
        func_t func;
        logic  out_busy;
    } uelt_stat_t;

endpackage

>>> design/uelt_if.sv
// request and response channel interfaces
interface uelt_req_if #(
    parameter int VERTEX_BITS = uelt_pkg::VERTEX_BITS_DEF
);
    import uelt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [VERTEX_BITS-1:0] vertex_a;
    logic [VERTEX_BITS-1:0] vertex_b;

    modport source (output valid, func, vertex_a, vertex_b, input ready);
    modport sink   (input valid, func, vertex_a, vertex_b, output ready);
endinterface

interface uelt_rsp_if;
    import uelt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 adjacent;
    logic [CNT_OUT_W-1:0] degree;
    logic [CNT_OUT_W-1:0] edges_held;

    modport source (output valid, status, adjacent, degree, edges_held, input ready);
    modport sink   (input valid, status, adjacent, degree, edges_held, output ready);
endinterface

>>> design/uelt_ctrl.sv
// sequencing state machine for one request at a time
module uelt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  uelt_pkg::uelt_stat_t stat,
    output uelt_pkg::uelt_cmd_t  cmd
);
    import uelt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.invalid)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.count_zero)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.func == FUNC_INSERT && !stat.hit && !stat.full)
                begin
                    state_next = ST_APPEND;
                end
                else if (stat.func == FUNC_REMOVE && stat.hit)
                begin
                    state_next = ST_FETCH_LAST;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_APPEND:
            begin
                state_next = ST_RESULT;
            end
            ST_FETCH_LAST:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:       cmd.scan_issue  = 1'b1;
            ST_DECIDE:     cmd.decide      = 1'b1;
            ST_APPEND:     cmd.append      = 1'b1;
            ST_FETCH_LAST: cmd.fetch_last  = 1'b1;
            ST_MOVE:       cmd.move        = 1'b1;
            ST_RESULT:     cmd.result_load = !stat.out_busy;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/uelt_datapath.sv
// edge store, scan compare, counters and response register
module uelt_datapath #(
    parameter int MAX_EDGES   = uelt_pkg::MAX_EDGES_DEF,
    parameter int VERTEX_BITS = uelt_pkg::VERTEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  uelt_pkg::uelt_cmd_t           cmd,
    output uelt_pkg::uelt_stat_t          stat,
    input  logic [VERTEX_BITS:0]          num_vertices,
    input  logic [uelt_pkg::FUNC_W-1:0]   in_func,
    input  logic [VERTEX_BITS-1:0]        in_vertex_a,
    input  logic [VERTEX_BITS-1:0]        in_vertex_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [uelt_pkg::STATUS_W-1:0] out_status,
    output logic                         out_adjacent,
    output logic [uelt_pkg::CNT_OUT_W-1:0] out_degree,
    output logic [uelt_pkg::CNT_OUT_W-1:0] out_edges_held
);
    import uelt_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int DW = 2 * VERTEX_BITS;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EDGES);

    // edge store, first endpoint in the upper half
    logic [DW-1:0] edge_mem [MAX_EDGES];

    logic [FUNC_W-1:0]      func_reg;
    logic [VERTEX_BITS-1:0] a_reg;
    logic [VERTEX_BITS-1:0] b_reg;
    logic [CW-1:0]          count_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          cmp_idx_reg;
    logic                   cmp_en_reg;
    logic [DW-1:0]          rd_data_reg;
    logic                   hit_reg;
    logic [AW-1:0]          hit_idx_reg;
    logic [CW-1:0]          deg_reg;
    logic                   drop_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic                   out_adjacent_reg;
    logic [CNT_OUT_W-1:0]   out_degree_reg;
    logic [CNT_OUT_W-1:0]   out_edges_reg;

    func_t                  func;
    logic                   a_ok;
    logic                   b_ok;
    logic                   invalid;
    logic [VERTEX_BITS-1:0] rd_first;
    logic [VERTEX_BITS-1:0] rd_second;
    logic                   pair_match;
    logic                   deg_match;
    logic [AW-1:0]          last_addr;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [DW-1:0]          wr_data;
    logic                   wr_en;
    status_t                status_val;

    // vertex range check
    assign func    = func_t'(func_reg);
    assign a_ok    = {1'b0, a_reg} < num_vertices;
    assign b_ok    = {1'b0, b_reg} < num_vertices;
    assign invalid = !a_ok || (func != FUNC_DEGREE && !b_ok);

    // compare the word read last cycle
    assign rd_first   = rd_data_reg[DW-1:VERTEX_BITS];
    assign rd_second  = rd_data_reg[VERTEX_BITS-1:0];
    assign pair_match = (rd_first == a_reg && rd_second == b_reg)
                     || (rd_first == b_reg && rd_second == a_reg);
    assign deg_match  = (rd_first == a_reg) || (rd_second == a_reg);

    // memory addressing
    assign last_addr = AW'(count_reg - CW'(1));
    assign rd_addr   = cmd.fetch_last ? last_addr : idx_reg;
    assign wr_addr   = cmd.append ? AW'(count_reg) : hit_idx_reg;
    assign wr_data   = cmd.append ? {a_reg, b_reg} : rd_data_reg;
    assign wr_en     = cmd.append || cmd.move;

    // edge store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            edge_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= edge_mem[rd_addr];
    end

    // request word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            a_reg    <= in_vertex_a;
            b_reg    <= in_vertex_b;
        end
        if (cmd.scan_issue)
        begin
            cmp_idx_reg <= idx_reg;
        end
    end

    // scan index, match tracking and degree count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            cmp_en_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
            deg_reg     <= '0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan_issue;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                deg_reg  <= '0;
                drop_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
                if (cmp_en_reg && pair_match && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                end
                if (cmp_en_reg && deg_match)
                begin
                    deg_reg <= deg_reg + CW'(1);
                end
                if (cmd.decide)
                begin
                    drop_reg <= (func == FUNC_INSERT) && !hit_reg
                             && (count_reg == CNT_MAX);
                end
            end
        end
    end

    // live edge count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.append)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.move)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // response status
    always_comb
    begin
        if (invalid)
        begin
            status_val = STATUS_BAD_VERTEX;
        end
        else if (drop_reg)
        begin
            status_val = STATUS_FULL;
        end
        else
        begin
            status_val = STATUS_OK;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_status_reg   <= status_val;
            out_adjacent_reg <= !invalid && func != FUNC_DEGREE && hit_reg;
            out_degree_reg   <= (!invalid && func == FUNC_DEGREE)
                              ? CNT_OUT_W'(deg_reg) : '0;
            out_edges_reg    <= CNT_OUT_W'(count_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_adjacent   = out_adjacent_reg;
    assign out_degree     = out_degree_reg;
    assign out_edges_held = out_edges_reg;

    // status to controller
    assign stat.invalid    = invalid;
    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_last  = (CW'(idx_reg) + CW'(1) == count_reg);
    assign stat.hit        = hit_reg;
    assign stat.full       = (count_reg == CNT_MAX);
    assign stat.func       = func;
    assign stat.out_busy   = out_valid_reg && !out_ready;

endmodule

>>> design/undirected_edge_list_table.sv
// top level of the undirected edge list table
// One request word is handled at a time. After the word is taken the block
// checks the vertices against num_vertices, then reads the live entries of
// the edge store through its single registered read port, one entry per
// cycle, then drains the compare and decides. An insert that appends then
// writes the new entry; a remove that hits reads the last entry and writes
// it over the hit. An invalid vertex is answered without the scan. The
// response sits in an output register, so the next request word is taken
// while it waits. num_vertices sits at byte address 0 and resets to 256 (or
// to 2**VERTEX_BITS when 256 does not fit its VERTEX_BITS+1 bits).
module undirected_edge_list_table #(
    parameter int MAX_EDGES   = uelt_pkg::MAX_EDGES_DEF,
    parameter int VERTEX_BITS = uelt_pkg::VERTEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    uelt_req_if.sink                        req,
    uelt_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uelt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [uelt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [uelt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import uelt_pkg::*;

    localparam int NV_W   = VERTEX_BITS + 1;
    localparam int NV_RAW = 256 % (2 ** NV_W);
    localparam logic [NV_W-1:0] NV_RESET =
        NV_W'((NV_RAW == 0) ? (2 ** VERTEX_BITS) : NV_RAW);

    logic [NV_W-1:0] num_vertices_reg;
    logic            cfg_write;
    uelt_cmd_t       cmd;
    uelt_stat_t      stat;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NUM_VERTICES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= NV_RESET;
        end
        else if (cfg_write)
        begin
            num_vertices_reg <= pwdata[NV_W-1:0];
        end
    end

    // register read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NUM_VERTICES)
        begin
            prdata[NV_W-1:0] = num_vertices_reg;
        end
    end

    // sequencer
    uelt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store and compare
    uelt_datapath #(
        .MAX_EDGES   (MAX_EDGES),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .num_vertices   (num_vertices_reg),
        .in_func        (req.func),
        .in_vertex_a    (req.vertex_a),
        .in_vertex_b    (req.vertex_b),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_status     (rsp.status),
        .out_adjacent   (rsp.adjacent),
        .out_degree     (rsp.degree),
        .out_edges_held (rsp.edges_held)
    );

endmodule

>>> design/uelt_checker.sv
// port-level checks for the edge list table, bound to the top level
module uelt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [uelt_pkg::STATUS_W-1:0]    rsp_status,
    input logic                             rsp_adjacent,
    input logic [uelt_pkg::CNT_OUT_W-1:0]   rsp_degree,
    input logic [uelt_pkg::CNT_OUT_W-1:0]   rsp_edges_held
);
    import uelt_pkg::*;

    // a stalled response word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
        && $stable(rsp_status) && $stable(rsp_adjacent)
        && $stable(rsp_degree) && $stable(rsp_edges_held))
    else $error("response word changed while stalled");

    // one request at a time: no word taken right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in progress");

    // a bad vertex touches nothing and reports no adjacency or degree
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_BAD_VERTEX |->
        !rsp_adjacent && rsp_degree == '0)
    else $error("bad vertex response carries data");

    // a dropped insert saw no match and asks no degree
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_FULL |->
        !rsp_adjacent && rsp_degree == '0)
    else $error("table full response carries data");

endmodule

bind undirected_edge_list_table uelt_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_adjacent   (rsp.adjacent),
    .rsp_degree     (rsp.degree),
    .rsp_edges_held (rsp.edges_held)
);

>>> tb/sv/uelt_table_checker.sv
// response checker for the undirected edge list table: predicts every request word and compares
module uelt_table_checker #(
    parameter int MAX_EDGES   = uelt_pkg::MAX_EDGES_DEF,
    parameter int VERTEX_BITS = uelt_pkg::VERTEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    uelt_req_if                             req,
    uelt_rsp_if                             rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [uelt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [uelt_pkg::APB_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              pending
);
    import uelt_pkg::*;

    typedef logic [VERTEX_BITS-1:0] vid_t;

    typedef struct packed {
        status_t              status;
        logic                 adjacent;
        logic [CNT_OUT_W-1:0] degree;
        logic [CNT_OUT_W-1:0] edges_held;
    } outcome_t;

    // shadow copy of the table and its register
    vid_t               end_u [MAX_EDGES];
    vid_t               end_v [MAX_EDGES];
    int                 live_edges;
    logic [VERTEX_BITS:0] vertex_limit;

    outcome_t awaited_outcomes[$];
    int       mismatches;
    int       rsp_seen;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("[%0t] response %0d: %s got %h, expected %h",
                 $time, rsp_seen, what, got, want);
    endtask

    // applies one request to the shadow table and returns the response it should give
    function automatic outcome_t apply_edge_op(input func_t op, input vid_t a, input vid_t b);
        outcome_t res;
        int       hit;
        int       last;
        int       i;
        res        = '0;
        res.status = STATUS_OK;
        hit        = -1;
        if (a >= vertex_limit || (op != FUNC_DEGREE && b >= vertex_limit)) begin
            res.status = STATUS_BAD_VERTEX;
        end
        else if (op == FUNC_DEGREE) begin
            // self loop touches a only once
            for (i = 0; i < live_edges; i++)
                if (end_u[i] == a || end_v[i] == a)
                    res.degree = res.degree + 1'b1;
        end
        else begin
            for (i = 0; i < live_edges && hit < 0; i++)
                if ((end_u[i] == a && end_v[i] == b) || (end_u[i] == b && end_v[i] == a))
                    hit = i;
            res.adjacent = (hit >= 0);
            if (op == FUNC_INSERT && hit < 0) begin
                if (live_edges >= MAX_EDGES) begin
                    res.status = STATUS_FULL;
                end
                else begin
                    end_u[live_edges] = a;
                    end_v[live_edges] = b;
                    live_edges++;
                end
            end
            else if (op == FUNC_REMOVE && hit >= 0) begin
                // last live entry fills the hole
                last       = live_edges - 1;
                end_u[hit] = end_u[last];
                end_v[hit] = end_v[last];
                live_edges = last;
            end
        end
        res.edges_held = CNT_OUT_W'(live_edges);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        outcome_t want;
        if (!rst_n) begin
            live_edges   = 0;
            vertex_limit = (VERTEX_BITS + 1)'(256);
            if (vertex_limit == '0)
                vertex_limit = (VERTEX_BITS + 1)'(1 << VERTEX_BITS);
            awaited_outcomes.delete();
            mismatches   = 0;
            rsp_seen     = 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else begin
            // register write
            if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_VERTICES)
                vertex_limit = pwdata[VERTEX_BITS:0];

            // response word: compare with the oldest expectation
            if (rsp.valid && rsp.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("unexpected word", 8'(rsp.status), 8'h00);
                end
                else begin
                    want = awaited_outcomes.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 8'(rsp.status), 8'(want.status));
                    if (rsp.adjacent !== want.adjacent)
                        report_mismatch("adjacent", 8'(rsp.adjacent), 8'(want.adjacent));
                    if (rsp.degree !== want.degree)
                        report_mismatch("degree", 8'(rsp.degree), 8'(want.degree));
                    if (rsp.edges_held !== want.edges_held)
                        report_mismatch("edges_held", 8'(rsp.edges_held), 8'(want.edges_held));
                end
                rsp_seen++;
            end

            // request word: predict its response
            if (req.valid && req.ready)
                awaited_outcomes.push_back(apply_edge_op(func_t'(req.func), req.vertex_a,
                                                         req.vertex_b));

            fail_count <= mismatches;
            pending    <= awaited_outcomes.size();
        end
    end

endmodule

>>> tb/sv/tb_undirected_edge_list_table.sv
// testbench top for the undirected edge list table: stimulus, pacing and verdict
module tb_undirected_edge_list_table;
    import uelt_pkg::*;

    localparam int MAX_EDGES   = MAX_EDGES_DEF;
    localparam int VERTEX_BITS = VERTEX_BITS_DEF;
    localparam int IDLE_LIMIT  = 2000;

    typedef logic [VERTEX_BITS-1:0] vid_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   checker_fails;
    int   pending_results;
    int   idle_cycles;
    bit   steady;
    logic [2*VERTEX_BITS-1:0] recent_pairs[$];

    uelt_req_if #(.VERTEX_BITS(VERTEX_BITS)) req_ch ();
    uelt_rsp_if                              rsp_ch ();

    undirected_edge_list_table #(
        .MAX_EDGES  (MAX_EDGES),
        .VERTEX_BITS(VERTEX_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .rsp    (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    uelt_table_checker #(
        .MAX_EDGES  (MAX_EDGES),
        .VERTEX_BITS(VERTEX_BITS)
    ) edge_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .fail_count(checker_fails),
        .pending   (pending_results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short gaps, now and then a long one; none at all in steady stretches
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // vertices cluster in a small pool so pairs repeat, with some from the full range
    function automatic vid_t pick_vertex(input int pool);
        if ($urandom_range(0, 99) < 75)
            return vid_t'($urandom_range(0, pool - 1));
        return vid_t'($urandom_range(0, (1 << VERTEX_BITS) - 1));
    endfunction

    function automatic func_t pick_op(input int ins_w, input int rem_w, input int qry_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            return FUNC_INSERT;
        if (r < ins_w + rem_w)
            return FUNC_REMOVE;
        if (r < ins_w + rem_w + qry_w)
            return FUNC_QUERY;
        return FUNC_DEGREE;
    endfunction

    // one request word; valid stays high afterwards until the next call or a drain
    task automatic send_word(input func_t op, input vid_t a, input vid_t b);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= op;
        req_ch.vertex_a <= a;
        req_ch.vertex_b <= b;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // stop sending and wait for every outstanding response word
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    // drain, let the block settle, then write num_vertices (setup then access)
    task automatic reconfigure(input int unsigned value);
        drain_results();
        repeat (8) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_NUM_VERTICES, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // random requests under one num_vertices setting, with one full drain midway
    task automatic run_phase(input int unsigned limit_val, input int items, input int pool,
                             input int ins_w, input int rem_w, input int qry_w,
                             input bit calm);
        func_t                    op;
        vid_t                     a;
        vid_t                     b;
        logic [2*VERTEX_BITS-1:0] pair;
        int                       i;
        reconfigure(limit_val);
        steady = calm;
        for (i = 0; i < items; i++)
        begin
            if (i == items / 2)
                drain_results();
            op = pick_op(ins_w, rem_w, qry_w);
            a  = pick_vertex(pool);
            b  = pick_vertex(pool);
            // reuse an inserted pair, either way round, so removes and queries hit
            if (op != FUNC_INSERT && recent_pairs.size() != 0 && $urandom_range(0, 1))
            begin
                pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
                if ($urandom_range(0, 1))
                begin
                    a = pair[2*VERTEX_BITS-1:VERTEX_BITS];
                    b = pair[VERTEX_BITS-1:0];
                end
                else
                begin
                    a = pair[VERTEX_BITS-1:0];
                    b = pair[2*VERTEX_BITS-1:VERTEX_BITS];
                end
            end
            if (op == FUNC_INSERT)
            begin
                recent_pairs.push_back({a, b});
                if (recent_pairs.size() > 48)
                    void'(recent_pairs.pop_front());
            end
            send_word(op, a, b);
        end
        steady = 1'b0;
    endtask

    // response side pacing
    initial
    begin : rsp_pacing
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            stall = pick_gap();
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    // watchdog on cycles with no word moving on any port
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] watchdog: no progress, %0d responses outstanding",
                     $time, pending_results);
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        steady           = 1'b0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FUNC_INSERT;
        req_ch.vertex_a <= '0;
        req_ch.vertex_b <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, both orientations, self loop
        send_word(FUNC_DEGREE, 8'd0,   8'd0);
        send_word(FUNC_QUERY,  8'd0,   8'd255);
        send_word(FUNC_REMOVE, 8'd0,   8'd255);
        send_word(FUNC_INSERT, 8'd0,   8'd255);
        send_word(FUNC_INSERT, 8'd255, 8'd0);
        send_word(FUNC_INSERT, 8'd255, 8'd255);
        send_word(FUNC_INSERT, 8'hAA,  8'h55);
        send_word(FUNC_INSERT, 8'h55,  8'hAA);
        send_word(FUNC_DEGREE, 8'd255, 8'd7);
        send_word(FUNC_DEGREE, 8'd0,   8'd255);
        send_word(FUNC_QUERY,  8'hAA,  8'h55);
        send_word(FUNC_QUERY,  8'h55,  8'hAA);
        send_word(FUNC_REMOVE, 8'd255, 8'd0);
        send_word(FUNC_DEGREE, 8'd255, 8'd0);
        send_word(FUNC_REMOVE, 8'h55,  8'hAA);
        send_word(FUNC_QUERY,  8'd0,   8'd255);

        // directed: invalid vertices on either side, degree ignores vertex_b
        reconfigure(5);
        send_word(FUNC_INSERT, 8'd5,   8'd1);
        send_word(FUNC_INSERT, 8'd1,   8'd5);
        send_word(FUNC_DEGREE, 8'd5,   8'd0);
        send_word(FUNC_DEGREE, 8'd4,   8'd200);
        send_word(FUNC_QUERY,  8'd4,   8'd4);
        send_word(FUNC_REMOVE, 8'd7,   8'd2);

        // directed: zero makes every vertex invalid, above the id range makes all valid
        reconfigure(0);
        send_word(FUNC_DEGREE, 8'd0,   8'd0);
        send_word(FUNC_INSERT, 8'd0,   8'd0);
        reconfigure(300);
        send_word(FUNC_INSERT, 8'd255, 8'd128);

        // random phases: fill to full, tiny and empty vertex ranges, drain, churn
        run_phase(256, 230, 24, 60, 10, 15, 1'b0);
        run_phase(1,    40,  3, 30, 20, 30, 1'b0);
        run_phase(0,    20,  4, 25, 25, 25, 1'b0);
        run_phase(511, 150, 32, 20, 40, 20, 1'b1);
        run_phase(12,  280, 14, 35, 30, 20, 1'b0);
        run_phase(256, 200, 40, 45, 25, 15, 1'b0);

        drain_results();
        repeat (80) @(posedge clk);
        if (checker_fails == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/uelt_pkg.sv
design/uelt_if.sv
design/uelt_ctrl.sv
design/uelt_datapath.sv
design/undirected_edge_list_table.sv
design/uelt_checker.sv
tb/sv/uelt_table_checker.sv
tb/sv/tb_undirected_edge_list_table.sv
